// ===== design/cau_pkg.sv =====
// Shared types and constants for the contiguous unit allocator.
// Used by the unit store, the run finder and the top level; depends on nothing.
`default_nettype none

package cau_pkg;

   // Default sizing
   localparam int UNITS_DEFAULT   = 256;
   localparam int ID_BITS_DEFAULT = 8;

   // Field widths of the stream items
   localparam int ID_IN_W    = 8;
   localparam int BASE_W     = 8;
   localparam int LEN_W      = 9;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // Request kinds, carried on req_tuser
   typedef enum logic [1:0] {
      REQ_MARK  = 2'd0,
      REQ_PLACE = 2'd1,
      REQ_FREE  = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   // Kind of one memory unit
   typedef enum logic [KIND_W-1:0] {
      KIND_RESERVED = 2'd0,
      KIND_HOLE     = 2'd1,
      KIND_ALLOC    = 2'd2
   } unit_kind_type;

   // Control from the sequencer to the run finder, one beat per unit read
   typedef struct packed {
      logic start;   // clear the search before a sweep
      logic beat;    // read data of one unit is valid
      logic hole;    // that unit is a hole
      logic last;    // that unit is the last one of the store
   } scan_ctl_type;

endpackage

`default_nettype wire

// ===== design/contiguous_unit_allocator.sv =====
// Contiguous unit allocator: after reset the store is swept once to mark every unit
// reserved, with req_tready low. Each request then runs alone against the unit store
// (one write port, one read port), one unit per cycle: a mark writes the units from
// base to base+length-1 (stopping at the last unit), a read looks at one unit, freeing
// sweeps the whole store, and a placement sweeps for runs, then writes the run when one
// fits or, when none does, runs the sweep that frees the owner. A zero-length placement
// answers without a sweep. A new request is taken while the previous result still waits on
// the response side. Uses cau_pkg, cau_store and cau_fit.
`default_nettype none

module contiguous_unit_allocator
   import cau_pkg::*;
#(
   parameter int UNITS   = UNITS_DEFAULT,
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: proc_id[7:0], seg_id[15:8], base[23:16], length[32:24], zeros above
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // request kind: req_type[1:0]
   input  wire logic [1:0]            req_tuser,
   // response: status[0], alloc_base[8:1], unit_kind[10:9], unit_proc[18:11],
   // unit_seg[26:19], zeros above
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   localparam int AW = $clog2(UNITS);
   localparam int MW = ((AW > LEN_W) ? AW : LEN_W) + 1;
   localparam int DW = KIND_W + 2 * ID_BITS;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_MARK  = 10'b00_0000_0100,
      ST_SCAN  = 10'b00_0000_1000,
      ST_PICK  = 10'b00_0001_0000,
      ST_PLACE = 10'b00_0010_0000,
      ST_FREE  = 10'b00_0100_0000,
      ST_READ  = 10'b00_1000_0000,
      ST_RDATA = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [MW-1:0]      cnt_ff, cnt_in;
   logic [ID_BITS-1:0] proc_ff, proc_in;
   logic [ID_BITS-1:0] seg_ff, seg_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               policy_ff, policy_in;

   logic               beat_ff, beat_in;
   logic               beat_last_ff, beat_last_in;
   logic [AW-1:0]      beat_addr_ff, beat_addr_in;

   logic               res_status_ff, res_status_in;
   logic [7:0]         res_base_ff, res_base_in;
   logic [KIND_W-1:0]  res_kind_ff, res_kind_in;
   logic [7:0]         res_proc_ff, res_proc_in;
   logic [7:0]         res_seg_ff, res_seg_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [DW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [DW-1:0] mem_rd_data;

   logic [KIND_W-1:0]  rd_kind;
   logic [ID_BITS-1:0] rd_proc;
   logic [ID_BITS-1:0] rd_seg;

   scan_ctl_type  scan_ctl;
   logic          fit_found;
   logic [AW-1:0] fit_where;

   logic          req_accept;
   logic [MW-1:0] mark_end;
   logic          sweep_issue;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rd_kind = mem_rd_data[KIND_W-1:0];
   assign rd_proc = mem_rd_data[KIND_W +: ID_BITS];
   assign rd_seg  = mem_rd_data[KIND_W+ID_BITS +: ID_BITS];

   assign mark_end    = MW'(base_ff) + MW'(len_ff);
   assign sweep_issue = cnt_ff < MW'(UNITS);

   cau_store #(
      .UNITS   (UNITS),
      .ID_BITS (ID_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      scan_ctl.start = req_accept && (req_kind_type'(req_tuser) == REQ_PLACE);
      scan_ctl.beat  = beat_ff && (state_ff == ST_SCAN);
      scan_ctl.hole  = (rd_kind == KIND_HOLE);
      scan_ctl.last  = beat_last_ff;
   end

   cau_fit #(
      .UNITS (UNITS)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .beat_addr (beat_addr_ff),
      .need      (len_ff),
      .best_fit  (policy_ff),
      .found     (fit_found),
      .where     (fit_where)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      proc_in       = proc_ff;
      seg_in        = seg_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      policy_in     = csr_wr_en ? csr_wr_data : policy_ff;
      beat_in       = 1'b0;
      beat_last_in  = 1'b0;
      beat_addr_in  = beat_addr_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      res_kind_in   = res_kind_ff;
      res_proc_in   = res_proc_ff;
      res_seg_in    = res_seg_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff[AW-1:0];
      mem_wr_data   = {{(2*ID_BITS){1'b0}}, KIND_HOLE};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cnt_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {{(2*ID_BITS){1'b0}}, KIND_RESERVED};
            cnt_in      = cnt_ff + MW'(1);
            if (cnt_ff == MW'(UNITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               proc_in       = ID_BITS'(req_tdata[7:0]);
               seg_in        = ID_BITS'(req_tdata[15:8]);
               base_in       = req_tdata[23:16];
               len_in        = req_tdata[32:24];
               res_status_in = 1'b0;
               res_base_in   = '0;
               res_kind_in   = '0;
               res_proc_in   = '0;
               res_seg_in    = '0;
               cnt_in        = '0;
               case (req_kind_type'(req_tuser))
                  REQ_MARK: begin
                     cnt_in   = MW'(req_tdata[23:16]);
                     state_in = ST_MARK;
                  end
                  REQ_PLACE: begin
                     // a zero-length segment always fits and changes nothing
                     state_in = (req_tdata[32:24] == '0) ? ST_DONE : ST_SCAN;
                  end
                  REQ_FREE:  state_in = ST_FREE;
                  REQ_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_MARK: begin
            if (cnt_ff < mark_end && sweep_issue) begin
               mem_wr_en = 1'b1;
               cnt_in    = cnt_ff + MW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (sweep_issue) begin
               mem_rd_en    = 1'b1;
               cnt_in       = cnt_ff + MW'(1);
               beat_in      = 1'b1;
               beat_last_in = (cnt_ff == MW'(UNITS - 1));
               beat_addr_in = cnt_ff[AW-1:0];
            end
            if (beat_ff && beat_last_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cnt_in = '0;
            if (fit_found) begin
               res_base_in = 8'(fit_where);
               state_in    = ST_PLACE;
            end else begin
               // no run fits: give back everything the process holds
               res_status_in = 1'b1;
               state_in      = ST_FREE;
            end
         end
         ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(MW'(fit_where) + cnt_ff);
            mem_wr_data = {seg_ff, proc_ff, KIND_ALLOC};
            cnt_in      = cnt_ff + MW'(1);
            if (cnt_ff + MW'(1) == MW'(len_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE: begin
            if (sweep_issue) begin
               mem_rd_en    = 1'b1;
               cnt_in       = cnt_ff + MW'(1);
               beat_in      = 1'b1;
               beat_last_in = (cnt_ff == MW'(UNITS - 1));
               beat_addr_in = cnt_ff[AW-1:0];
            end
            // write back one unit behind the read
            if (beat_ff && rd_kind == KIND_ALLOC && rd_proc == proc_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = beat_addr_ff;
            end
            if (beat_ff && beat_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            mem_rd_en   = MW'(base_ff) < MW'(UNITS);
            mem_rd_addr = AW'(base_ff);
            state_in    = ST_RDATA;
         end
         ST_RDATA: begin
            if (MW'(base_ff) < MW'(UNITS)) begin
               res_kind_in = rd_kind;
               if (rd_kind == KIND_ALLOC) begin
                  res_proc_in = 8'(rd_proc);
                  res_seg_in  = 8'(rd_seg);
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'({res_seg_ff, res_proc_ff, res_kind_ff,
                                            res_base_ff, res_status_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         policy_ff     <= 1'b0;
         beat_ff       <= 1'b0;
         beat_last_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         policy_ff     <= policy_in;
         beat_ff       <= beat_in;
         beat_last_ff  <= beat_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      proc_ff       <= proc_in;
      seg_ff        <= seg_in;
      base_ff       <= base_in;
      len_ff        <= len_in;
      beat_addr_ff  <= beat_addr_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      res_kind_ff   <= res_kind_in;
      res_proc_ff   <= res_proc_in;
      res_seg_ff    <= res_seg_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (MW'(mem_wr_addr) < MW'(UNITS)))
      else $error("store write beyond the last unit");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_PICK) |-> !mem_wr_en)
      else $error("store written during run search");

   a_free_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE && mem_wr_en) |-> (mem_wr_addr == $past(mem_rd_addr)))
      else $error("free write-back not aligned with the unit read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

endmodule

`default_nettype wire

// ===== design/cau_store.sv =====
// Unit store: one entry per memory unit holding kind, owner and segment id.
// Single write port, single read port with registered read data. Uses cau_pkg.
`default_nettype none

module cau_store
   import cau_pkg::*;
#(
   parameter int UNITS   = UNITS_DEFAULT,
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(UNITS)-1:0]  wr_addr,
   input  wire logic [KIND_W+2*ID_BITS-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(UNITS)-1:0]  rd_addr,
   output logic      [KIND_W+2*ID_BITS-1:0] rd_data
);

   localparam int DW = KIND_W + 2 * ID_BITS;

   logic [DW-1:0] unit_mem [UNITS];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         unit_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= unit_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/cau_fit.sv =====
// Run finder: tracks runs of hole units over a sweep and keeps the chosen run.
// First fit keeps the lowest qualifying run, best fit the shortest. Uses cau_pkg.
`default_nettype none

module cau_fit
   import cau_pkg::*;
#(
   parameter int UNITS = UNITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire scan_ctl_type             ctl,
   input  wire logic [$clog2(UNITS)-1:0] beat_addr,
   input  wire logic [LEN_W-1:0]         need,
   input  wire logic                     best_fit,
   output logic                          found,
   output logic [$clog2(UNITS)-1:0]      where
);

   localparam int AW = $clog2(UNITS);
   localparam int LW = AW + 1;
   localparam int CW = (LW > LEN_W) ? LW : LEN_W;

   logic [LW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] run_start_ff, run_start_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic [AW-1:0] best_base_ff, best_base_in;
   logic          found_ff, found_in;

   logic [LW-1:0] len_inc;
   logic [AW-1:0] start_inc;
   logic [LW-1:0] cand_len;
   logic [AW-1:0] cand_start;
   logic          run_ends;
   logic          fits;

   always_comb begin
      len_inc    = run_len_ff + LW'(1);
      start_inc  = (run_len_ff == '0) ? beat_addr : run_start_ff;
      cand_len   = ctl.hole ? len_inc : run_len_ff;
      cand_start = ctl.hole ? start_inc : run_start_ff;
      run_ends   = !ctl.hole || ctl.last;
      fits       = (cand_len != '0) && (CW'(cand_len) >= CW'(need));

      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      best_len_in  = best_len_ff;
      best_base_in = best_base_ff;
      found_in     = found_ff;

      if (ctl.start) begin
         run_len_in   = '0;
         run_start_in = '0;
         best_len_in  = '0;
         best_base_in = '0;
         found_in     = 1'b0;
      end else if (ctl.beat) begin
         // a closed run competes; first fit never replaces its first pick
         if (run_ends && fits && (!found_ff || (best_fit && cand_len < best_len_ff))) begin
            found_in     = 1'b1;
            best_len_in  = cand_len;
            best_base_in = cand_start;
         end
         run_len_in   = (ctl.hole && !ctl.last) ? len_inc : '0;
         run_start_in = start_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         run_len_ff <= '0;
      end else begin
         found_ff   <= found_in;
         run_len_ff <= run_len_in;
      end
      run_start_ff <= run_start_in;
      best_len_ff  <= best_len_in;
      best_base_ff <= best_base_in;
   end

   assign found = found_ff;
   assign where = best_base_ff;

endmodule

`default_nettype wire
